// ===== sv/tfst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_pkg
// Shared types, constants and helpers of the TCP flow statistics table.
// ----------------------------------------------------------------------------
package tfst_pkg;

    localparam int FLOW_SLOTS = 256;
    localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int USED_W     = SLOT_W + 1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;

    localparam logic [31:0] PKT_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_HIT     = 3'd1,
        ST_IGNORED = 3'd2,
        ST_FULL    = 3'd3,
        ST_READ    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CMD_COUNT  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_IGNORE = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [31:0] pkts;
        logic [47:0] bytes;
        logic [47:0] pays;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // classified request handed from front to back
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  slot_index;
        logic [15:0] frame_length;
        logic [15:0] payload;
        t_key        key;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_UPDATE,
        B_RD_WAIT
    } t_bstate;

    // saturating 48-bit add of a 16-bit amount
    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {33'd0, b};
        return s[48] ? CNT_MAX : s[47:0];
    endfunction

endpackage

// ===== sv/tfst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_in_if / tfst_out_if
// Valid/ready channels carrying packet headers in and results out.
// ----------------------------------------------------------------------------
interface tfst_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  slot_index;
    logic [15:0] frame_length;
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [3:0]  ip_header_words;
    logic [15:0] ip_total_length;
    logic [3:0]  tcp_offset_words;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;

    modport source (output valid, mode, slot_index, frame_length, eth_type, ip_protocol,
                    ip_header_words, ip_total_length, tcp_offset_words, source_address,
                    destination_address, source_port, destination_port, input ready);
    modport sink   (input valid, mode, slot_index, frame_length, eth_type, ip_protocol,
                    ip_header_words, ip_total_length, tcp_offset_words, source_address,
                    destination_address, source_port, destination_port, output ready);
endinterface

interface tfst_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic        entry_valid;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
    logic [47:0] payload_total;
    logic [31:0] flow_source_address;
    logic [31:0] flow_destination_address;
    logic [15:0] flow_source_port;
    logic [15:0] flow_destination_port;

    modport source (output valid, status, slot, entry_valid, packet_total, byte_total,
                    payload_total, flow_source_address, flow_destination_address,
                    flow_source_port, flow_destination_port, input ready);
    modport sink   (input valid, status, slot, entry_valid, packet_total, byte_total,
                    payload_total, flow_source_address, flow_destination_address,
                    flow_source_port, flow_destination_port, output ready);
endinterface

// ===== sv/tfst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/tfst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_front
// Accepts header requests, classifies them, computes the TCP payload size
// and queues them in a two-entry FIFO for the table engine.
// ----------------------------------------------------------------------------
module tfst_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfst_in_if.sink       i_in,
    output logic          o_q_valid,
    output tfst_pkg::t_cmd o_q_data,
    input  logic          i_q_pop
);
    tfst_pkg::t_cmd r_fifo [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    tfst_pkg::t_cmd c_cmd;
    logic [6:0]     c_hdr;
    logic           c_push;

    // classify and size the payload
    always_comb begin
        c_hdr = {1'b0, i_in.ip_header_words, 2'b00} + {1'b0, i_in.tcp_offset_words, 2'b00};
        c_cmd.slot_index   = i_in.slot_index;
        c_cmd.frame_length = i_in.frame_length;
        c_cmd.payload      = (i_in.ip_total_length > {9'd0, c_hdr})
                           ? i_in.ip_total_length - {9'd0, c_hdr} : 16'd0;
        c_cmd.key.src      = i_in.source_address;
        c_cmd.key.dst      = i_in.destination_address;
        c_cmd.key.sport    = i_in.source_port;
        c_cmd.key.dport    = i_in.destination_port;
        if (i_in.mode) begin
            c_cmd.kind = tfst_pkg::CMD_READ;
        end else if (i_in.eth_type != tfst_pkg::ETHERTYPE_IPV4 ||
                     i_in.ip_protocol != tfst_pkg::PROTO_TCP) begin
            c_cmd.kind = tfst_pkg::CMD_IGNORE;
        end else begin
            c_cmd.kind = tfst_pkg::CMD_COUNT;
        end
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign c_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_fifo[r_rp];

    // hold queued requests
    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_fifo[r_wp] <= c_cmd;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, c_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ===== sv/tfst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_back
// Table engine: scans the flow RAM for a key match, allocates new flows,
// updates saturating counters and serves slot reads into an output register.
// ----------------------------------------------------------------------------
module tfst_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  tfst_pkg::t_cmd i_q_data,
    output logic           o_q_pop,
    tfst_out_if.source     o_out
);
    localparam int SW = tfst_pkg::SLOT_W;
    localparam int UW = tfst_pkg::USED_W;
    localparam logic [UW-1:0] SLOTS = UW'(tfst_pkg::FLOW_SLOTS);

    tfst_pkg::t_bstate r_state, n_state;
    tfst_pkg::t_cmd    r_cmd;
    logic [UW-1:0]     r_used;
    logic [UW-1:0]     r_idx;
    logic [SW-1:0]     r_pidx;
    logic              r_pend;
    logic [SW-1:0]     r_slot;
    logic              r_new;
    logic [31:0]       r_pkts;
    logic [47:0]       r_bytes;
    logic [47:0]       r_pays;

    logic              r_ovalid;
    tfst_pkg::t_status r_ostatus;
    logic [7:0]        r_oslot;
    logic              r_oentry;
    tfst_pkg::t_entry  r_oent;

    logic              ram_we;
    logic [SW-1:0]     ram_raddr;
    tfst_pkg::t_entry  ram_wdata;
    tfst_pkg::t_entry  ram_rdata;

    logic              c_start;
    logic              c_hit;
    logic              c_end;
    logic              c_rd_ok;
    logic              c_set_ovalid;
    logic [SW+7:0]     c_idx_ext;
    logic [SW+7:0]     c_slot_ext;
    tfst_pkg::t_entry  c_upd;

    tfst_ram #(
        .WIDTH (tfst_pkg::ENTRY_W),
        .DEPTH (tfst_pkg::FLOW_SLOTS)
    ) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control terms
    always_comb begin
        c_start    = (r_state == tfst_pkg::B_IDLE) && i_q_valid && (!r_ovalid || o_out.ready);
        c_hit      = r_pend && (ram_rdata.key == r_cmd.key);
        c_end      = (r_idx == r_used);
        c_idx_ext  = {{SW{1'b0}}, i_q_data.slot_index};
        c_rd_ok    = (c_idx_ext < {7'd0, r_used});
        c_slot_ext = {8'd0, r_slot};
        c_upd.key   = r_cmd.key;
        c_upd.pkts  = (r_pkts == tfst_pkg::PKT_MAX) ? r_pkts : r_pkts + 32'd1;
        c_upd.bytes = tfst_pkg::sat_add48(r_bytes, r_cmd.frame_length);
        c_upd.pays  = tfst_pkg::sat_add48(r_pays, r_cmd.payload);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tfst_pkg::B_IDLE: begin
                if (c_start) begin
                    case (i_q_data.kind)
                        tfst_pkg::CMD_COUNT: n_state = tfst_pkg::B_SCAN;
                        tfst_pkg::CMD_READ:  n_state = c_rd_ok ? tfst_pkg::B_RD_WAIT
                                                               : tfst_pkg::B_IDLE;
                        default:             n_state = tfst_pkg::B_IDLE;
                    endcase
                end
            end
            tfst_pkg::B_SCAN: begin
                if (c_hit) begin
                    n_state = tfst_pkg::B_UPDATE;
                end else if (c_end) begin
                    n_state = (r_used == SLOTS) ? tfst_pkg::B_IDLE : tfst_pkg::B_UPDATE;
                end
            end
            tfst_pkg::B_UPDATE:  n_state = tfst_pkg::B_IDLE;
            tfst_pkg::B_RD_WAIT: n_state = tfst_pkg::B_IDLE;
            default:             n_state = tfst_pkg::B_IDLE;
        endcase
    end

    // outputs: queue pop, RAM port control and result load
    always_comb begin
        o_q_pop      = c_start;
        ram_we       = 1'b0;
        ram_wdata    = c_upd;
        ram_raddr    = r_idx[SW-1:0];
        c_set_ovalid = 1'b0;
        case (r_state)
            tfst_pkg::B_IDLE: begin
                ram_raddr    = c_idx_ext[SW-1:0];
                c_set_ovalid = c_start && (i_q_data.kind != tfst_pkg::CMD_COUNT) &&
                               !((i_q_data.kind == tfst_pkg::CMD_READ) && c_rd_ok);
            end
            tfst_pkg::B_SCAN: begin
                c_set_ovalid = !c_hit && c_end && (r_used == SLOTS);
            end
            tfst_pkg::B_UPDATE: begin
                ram_we       = 1'b1;
                c_set_ovalid = 1'b1;
            end
            tfst_pkg::B_RD_WAIT: c_set_ovalid = 1'b1;
            default:             ram_raddr    = r_idx[SW-1:0];
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tfst_pkg::B_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= c_set_ovalid || (r_ovalid && !o_out.ready);
            case (r_state)
                tfst_pkg::B_IDLE: r_pend <= 1'b0;
                tfst_pkg::B_SCAN: r_pend <= !c_hit && !c_end;
                tfst_pkg::B_UPDATE: begin
                    if (r_new) begin
                        r_used <= r_used + UW'(1);
                    end
                end
                default: r_pend <= 1'b0;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            tfst_pkg::B_IDLE: begin
                r_idx <= '0;
                if (c_start) begin
                    r_cmd <= i_q_data;
                    // requests that finish here without a table access
                    r_oslot   <= (i_q_data.kind == tfst_pkg::CMD_READ)
                               ? i_q_data.slot_index : 8'd0;
                    r_ostatus <= (i_q_data.kind == tfst_pkg::CMD_READ)
                               ? tfst_pkg::ST_READ : tfst_pkg::ST_IGNORED;
                    r_oentry  <= 1'b0;
                    r_oent    <= '0;
                end
            end
            tfst_pkg::B_SCAN: begin
                if (c_hit) begin
                    r_slot  <= r_pidx;
                    r_new   <= 1'b0;
                    r_pkts  <= ram_rdata.pkts;
                    r_bytes <= ram_rdata.bytes;
                    r_pays  <= ram_rdata.pays;
                end else if (c_end) begin
                    r_slot    <= r_used[SW-1:0];
                    r_new     <= 1'b1;
                    r_pkts    <= '0;
                    r_bytes   <= '0;
                    r_pays    <= '0;
                    r_ostatus <= tfst_pkg::ST_FULL;
                    r_oslot   <= 8'd0;
                    r_oentry  <= 1'b0;
                    r_oent    <= '0;
                end else begin
                    r_pidx <= r_idx[SW-1:0];
                    r_idx  <= r_idx + UW'(1);
                end
            end
            tfst_pkg::B_UPDATE: begin
                r_ostatus <= r_new ? tfst_pkg::ST_NEW : tfst_pkg::ST_HIT;
                r_oslot   <= c_slot_ext[7:0];
                r_oentry  <= 1'b1;
                r_oent    <= c_upd;
            end
            tfst_pkg::B_RD_WAIT: begin
                r_ostatus <= tfst_pkg::ST_READ;
                r_oslot   <= r_cmd.slot_index;
                r_oentry  <= 1'b1;
                r_oent    <= ram_rdata;
            end
            default: r_idx <= '0;
        endcase
    end

    // drive the result channel from the output register
    assign o_out.valid                    = r_ovalid;
    assign o_out.status                   = r_ostatus;
    assign o_out.slot                     = r_oslot;
    assign o_out.entry_valid              = r_oentry;
    assign o_out.packet_total             = r_oent.pkts;
    assign o_out.byte_total               = r_oent.bytes;
    assign o_out.payload_total            = r_oent.pays;
    assign o_out.flow_source_address      = r_oent.key.src;
    assign o_out.flow_destination_address = r_oent.key.dst;
    assign o_out.flow_source_port         = r_oent.key.sport;
    assign o_out.flow_destination_port    = r_oent.key.dport;
endmodule

// ===== sv/tcp_flow_statistics_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_statistics_table_core
// Per-flow packet, byte and payload counters for IPv4/TCP traffic.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. Non-TCP packets and slot reads
// finish without a scan. A counted packet scans the flow table one stored
// key per cycle through the single read port of the flow RAM, reading up
// to FLOW_SLOTS keys when the table is full. A two-entry request queue lets
// headers arrive while a scan runs, and the output register holds a
// result until it is taken.
module tcp_flow_statistics_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfst_in_if.sink     i_in,
    tfst_out_if.source  o_out
);
    logic           q_valid;
    logic           q_pop;
    tfst_pkg::t_cmd q_data;

    tfst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    tfst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );
endmodule
